// ----- hw/rtl/sspq_pkg.sv -----
// Shared types and codes for the stable sorted priority queue.
// Used by sspq_mem, sspq_ctrl, stable_sorted_priority_queue_unit and the testbench; no dependencies.
`default_nettype none

package sspq_pkg;

  // request kinds
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] person_id;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_prio;
    logic [4:0]  occupancy;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sspq_mem.sv -----
// Entry store: one write port, one read port, registered read data.
// Uses sspq_pkg for the entry type.
`default_nettype none

module sspq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [AW-1:0]         wr_addr,
  input  sspq_pkg::entry_t     wr_data,
  input  wire                  rd_en,
  input  wire [AW-1:0]         rd_addr,
  output sspq_pkg::entry_t     rd_data
);
  import sspq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sspq_ctrl.sv -----
// Sequencer for the queue: circular buffer in sspq_mem, head pointer and count.
// Insert walks from the tail toward the head, moving larger entries up one slot.
// Uses sspq_pkg for entry, result and status codes.
`default_nettype none

module sspq_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  wire                  clk,
  input  wire                  rst,
  // request side
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_cmd,
  input  sspq_pkg::entry_t     in_entry,
  // result side
  output logic                 res_valid,
  input  wire                  res_free,
  output sspq_pkg::result_t    res_data,
  // memory port
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output sspq_pkg::entry_t     wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  sspq_pkg::entry_t     rd_data
);
  import sspq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_REPLY = 3'd4;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W   = (AW+1)'(DEPTH);

  logic [2:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] addr, addr_next;
  logic [CW-1:0] left, left_next;
  entry_t        key, key_next;
  result_t       res, res_next;

  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] tail_prev;
  logic [AW-1:0] addr_prev;
  logic [AW-1:0] addr_prev2;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [31:0]   occ_inc_w;
  logic [31:0]   occ_dec_w;
  logic [31:0]   occ_w;

  function automatic logic [AW-1:0] prev_addr(input logic [AW-1:0] a);
    prev_addr = (a == '0) ? LAST_ADDR : a - AW'(1);
  endfunction

  always_comb begin
    tail_sum   = {1'b0, head} + (AW+1)'(count);
    tail       = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
    tail_prev  = prev_addr(tail);
    addr_prev  = prev_addr(addr);
    addr_prev2 = prev_addr(addr_prev);
    head_inc   = (head == LAST_ADDR) ? '0 : head + AW'(1);
    count_inc  = count + CW'(1);
    count_dec  = count - CW'(1);
    occ_inc_w  = 32'(count_inc);
    occ_dec_w  = 32'(count_dec);
    occ_w      = 32'(count);
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_REPLY);
  assign res_data  = res;

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    addr_next  = addr;
    left_next  = left;
    key_next   = key;
    res_next   = res;
    wr_en      = 1'b0;
    wr_addr    = addr;
    wr_data    = key;
    rd_en      = 1'b0;
    rd_addr    = addr_prev2;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_INSERT) begin
            if (count == FULL_CNT) begin
              res_next   = '{ST_FULL, 16'd0, 8'd0, occ_w[4:0]};
              state_next = S_REPLY;
            end else begin
              key_next   = in_entry;
              count_next = count_inc;
              res_next   = '{ST_INSERTED, 16'd0, 8'd0, occ_inc_w[4:0]};
              addr_next  = tail;
              left_next  = count;
              if (count == '0) begin
                state_next = S_PLACE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = tail_prev;
                state_next = S_SHIFT;
              end
            end
          end else begin
            if (count == '0) begin
              res_next   = '{ST_EMPTY, 16'd0, 8'd0, occ_w[4:0]};
              state_next = S_REPLY;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head;
              count_next = count_dec;
              res_next   = '{ST_REMOVED, 16'd0, 8'd0, occ_dec_w[4:0]};
              state_next = S_POP;
            end
          end
        end
      end
      S_POP: begin
        res_next.out_id   = rd_data.person_id;
        res_next.out_prio = rd_data.prio;
        head_next         = head_inc;
        state_next        = S_REPLY;
      end
      S_SHIFT: begin
        wr_en = 1'b1;
        // strictly larger priorities move up; equal ones stay ahead
        if (rd_data.prio > key.prio) begin
          wr_data   = rd_data;
          addr_next = addr_prev;
          left_next = left - CW'(1);
          if (left == CW'(1)) begin
            state_next = S_PLACE;
          end else begin
            rd_en = 1'b1;
          end
        end else begin
          state_next = S_REPLY;
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    left <= left_next;
    key  <= key_next;
    res  <= res_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stable_sorted_priority_queue_unit.sv -----
// Stable sorted priority queue, top level with stream ports and output register.
// Instantiates sspq_ctrl and sspq_mem; uses sspq_pkg.
//
// Usage:
//   s_axis carries requests: tuser is the command (0 insert, 1 remove),
//   tdata holds person_id and prio. m_axis returns one result per request:
//   tuser is the status (0 inserted, 1 removed, 2 empty, 3 full), tdata holds
//   out_id, out_prio and occupancy.
//   Entries live in a circular buffer in a single-port-read, single-port-write
//   RAM; a remove reads the head slot, an insert walks from the tail toward
//   the head, one slot per cycle, moving entries with a larger priority up.
// One request is in flight at a time: the controller returns to idle as the
//   result moves into the output register and only then takes the next request,
//   so the walk through the RAM sets the rate.
// Reset (rst, synchronous) empties the queue; RAM contents are not cleared.
// A stalled m_axis holds the result; a new request can still be accepted
// and worked on, and its result waits until the output register frees up.
`default_nettype none

module stable_sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // [15:0] person_id, [23:16] prio
  input  wire         s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_id, [23:16] out_prio,
                                      // [28:24] occupancy, [31:29] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import sspq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        in_entry;
  logic          res_valid;
  logic          res_free;
  result_t       res_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  result_t       out_reg;

  assign in_entry = '{s_axis_tdata[23:16], s_axis_tdata[15:0]};
  assign res_free = !m_axis_tvalid || m_axis_tready;

  sspq_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .in_entry  (in_entry),
    .res_valid (res_valid),
    .res_free  (res_free),
    .res_data  (res_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  sspq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_free) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_reg <= res_data;
    end
  end

  assign m_axis_tdata = {3'b000, out_reg.occupancy, out_reg.out_prio, out_reg.out_id};
  assign m_axis_tuser = out_reg.status;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for stable_sorted_priority_queue_unit: stream driver, monitor and an
// in-bench sorted queue predictor with stable tie ordering. Depends on sspq_pkg and the RTL.
module testbench;
  import sspq_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_REQS = 1300;
  localparam int STALL_AFTER = 300;   // accepted requests before the long receiver hold-off
  localparam int STALL_LEN   = 300;
  localparam int CALM_START  = 4000;  // cycle window without idling on either side
  localparam int CALM_END    = 7000;

  typedef struct packed {
    logic        cmd;
    logic [15:0] person_id;
    logic [7:0]  prio;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // [15:0] person_id, [23:16] prio
  logic        s_axis_tuser = 1'b0;  // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [15:0] out_id, [23:16] out_prio, [28:24] occupancy
  logic [1:0]  m_axis_tuser;         // [1:0] status

  request_t request_backlog[$];
  result_t  due_results[$];
  entry_t   model_slots[QDEPTH];
  int       model_count = 0;
  int       mismatch_count = 0;
  int       sent_count = 0;
  int       cycle_no = 0;
  int       stall_left = 0;
  bit       stall_fired = 1'b0;

  stable_sorted_priority_queue_unit #(.QUEUE_DEPTH(QDEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // Updates the queue image for one request and returns the result it must produce.
  function automatic result_t predict_result(request_t req);
    result_t res;
    int pos;
    res = '0;
    if (req.cmd == CMD_INSERT) begin
      if (model_count >= QDEPTH) begin
        res.status = ST_FULL;
      end else begin
        // new entry goes behind every held entry of equal or smaller priority
        pos = 0;
        while (pos < model_count && model_slots[pos].prio <= req.prio) pos++;
        for (int k = model_count; k > pos; k--) model_slots[k] = model_slots[k - 1];
        model_slots[pos].prio      = req.prio;
        model_slots[pos].person_id = req.person_id;
        model_count++;
        res.status = ST_INSERTED;
      end
    end else if (model_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status   = ST_REMOVED;
      res.out_id   = model_slots[0].person_id;
      res.out_prio = model_slots[0].prio;
      for (int k = 1; k < model_count; k++) model_slots[k - 1] = model_slots[k];
      model_count--;
    end
    res.occupancy = 5'(model_count);
    return res;
  endfunction

  function automatic bit take_break();
    if (cycle_no >= CALM_START && cycle_no < CALM_END) return 1'b0;
    return $urandom_range(99) < 14;
  endfunction

  task automatic queue_request(logic cmd, logic [15:0] person_id, logic [7:0] prio);
    request_t req;
    req.cmd       = cmd;
    req.person_id = person_id;
    req.prio      = prio;
    request_backlog.push_back(req);
  endtask

  // Driver: valid is held until accepted, then the next request may follow at once.
  always @(posedge clk) begin : driver
    request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        req = request_backlog.pop_front();
        due_results.push_back(predict_result(req));
        sent_count++;
      end
      if (request_backlog.size() != 0 && !take_break()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= request_backlog[0].cmd;
        s_axis_tdata  <= {request_backlog[0].prio, request_backlog[0].person_id};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off so that the unit backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (!stall_fired && sent_count >= STALL_AFTER) begin
      stall_left  <= STALL_LEN;
      stall_fired <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = m_axis_tuser;
        got.out_id    = m_axis_tdata[15:0];
        got.out_prio  = m_axis_tdata[23:16];
        got.occupancy = m_axis_tdata[28:24];
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status=%0d id=%h prio=%0d occ=%0d",
                     got.status, got.out_id, got.out_prio, got.occupancy);
        end else begin
          want = due_results.pop_front();
          if (got !== want || m_axis_tdata[31:29] !== 3'b000) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: exp status=%0d id=%h prio=%0d occ=%0d",
                       want.status, want.out_id, want.out_prio, want.occupancy);
              $display("          got status=%0d id=%h prio=%0d occ=%0d pad=%b",
                       got.status, got.out_id, got.out_prio, got.occupancy,
                       m_axis_tdata[31:29]);
            end
          end
        end
      end
      m_axis_tready <= (stall_left == 0) && !take_break();
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("stable_sorted_priority_queue_unit test failed");
    $finish;
  end

  initial begin : stimulus
    int mode;
    int ins_pct;
    int pick;
    logic [7:0] pr;

    // directed: empty remove, extremes, ties at both ends, fill to full, full rejects
    queue_request(CMD_REMOVE, 16'hffff, 8'hff);
    queue_request(CMD_INSERT, 16'h0000, 8'd255);
    queue_request(CMD_INSERT, 16'hffff, 8'd0);
    queue_request(CMD_INSERT, 16'h0001, 8'd255);
    for (int i = 0; i < 13; i++)
      queue_request(CMD_INSERT, 16'h1000 + 16'(i),
                    (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd128 : 8'd255);
    queue_request(CMD_INSERT, 16'h2222, 8'd0);
    queue_request(CMD_INSERT, 16'hffff, 8'hff);
    for (int i = 0; i < 5; i++) queue_request(CMD_REMOVE, 16'hffff, 8'hff);

    // random: runs biased toward filling, draining or churning the queue
    ins_pct = 50;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) begin
        mode = $urandom_range(2);
        ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 55;
      end
      pick = $urandom_range(99);
      if (pick < 40) pr = 8'($urandom_range(3));         // dense ties
      else if (pick < 50) pr = $urandom_range(1) ? 8'hff : 8'h00;
      else pr = 8'($urandom);
      queue_request(($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE,
                    16'($urandom), pr);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && due_results.size() == 0)
      $display("stable_sorted_priority_queue_unit test passed");
    else
      $display("stable_sorted_priority_queue_unit test failed");
    $finish;
  end

endmodule
